// File: hw/rtl/sst_pkg.sv
// Shared types and constants for the sorted score table.
`default_nettype none
package sst_pkg;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int NUM_BOARDS_DEF = 4;
    localparam int MAX_READ_DEF = 16;

    localparam logic [1:0] OP_PROPOSE = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [1:0] board;
        logic [15:0] user_id;
        logic signed [31:0] score;
        logic [15:0] extra_tag;
        logic [31:0] time_stamp;
        logic [5:0] start_rank;
        logic [4:0] read_count;
        logic worst_first;
    } cmd_t;

    typedef struct packed {
        logic [6:0] rank;
        logic valid_res;
        logic [6:0] board_size;
        logic [3:0] read_index;
        logic [15:0] entry_user;
        logic signed [31:0] entry_score;
        logic [15:0] entry_tag;
        logic last;
    } res_t;

    // one stored entry
    typedef struct packed {
        logic [31:0] score;
        logic [31:0] tstamp;
        logic [15:0] user;
        logic [15:0] tag;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SHIFT, ST_READ, ST_OUT
    } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/sst_if.sv
// Valid/ready channel interfaces for commands, results and configuration.
`default_nettype none
interface sst_cmd_if;
    logic valid;
    logic ready;
    sst_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sst_res_if;
    logic valid;
    logic ready;
    sst_pkg::res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sst_cfg_if;
    logic valid;
    logic ready;
    logic data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/sst_mem.sv
// Entry memory: one write port, one registered read port.
`default_nettype none
module sst_mem #(
    parameter int AW = 8
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [AW-1:0] waddr,
    input wire sst_pkg::entry_t wdata,
    input wire logic [AW-1:0] raddr,
    output sst_pkg::entry_t rdata
);
    sst_pkg::entry_t mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/sorted_score_table.sv
// Top level of the sorted score table.
// Boards are kept sorted best first in one entry memory (NUM_BOARDS*TABLE_DEPTH
// entries, one read and one write a cycle, registered read data). Propose and
// add scan the board from rank 0, one entry a cycle; the scan stops when the data
// of the first entry that the score beats returns (for an add, also an equal score
// with a later stored time stamp), or at the end of the board, and the result is
// then loaded. An add then moves the tail down one entry at a time (read, then
// write back), from the end of the board toward the insert position, and then
// places the new entry.
// Clear, a rejected add and an empty read load their result one cycle after accept.
// A read fetches one entry at a time, and fetches the next only once the result
// for the last one has been taken. One item is at work at a time; the next is
// accepted once the last result of the current one has been taken.
`default_nettype none
module sorted_score_table #(
    parameter int TABLE_DEPTH = sst_pkg::TABLE_DEPTH_DEF,
    parameter int NUM_BOARDS = sst_pkg::NUM_BOARDS_DEF,
    parameter int MAX_READ = sst_pkg::MAX_READ_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    sst_cmd_if.sink cmd,
    sst_res_if.source res,
    sst_cfg_if.sink cfg
);
    localparam int DW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int BW = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;
    localparam int AW = DW + BW;
    localparam int RW = $clog2(MAX_READ + 1);

    sst_pkg::state_t state_reg, state_next;
    sst_pkg::cmd_t cmd_reg;
    logic lower_reg;
    logic [CW-1:0] count_reg [NUM_BOARDS];
    logic [CW-1:0] size_reg;
    logic [BW-1:0] bsel_reg;
    logic [CW-1:0] idx_reg, idx_next;     // issue index
    logic [CW-1:0] pos_reg;               // insert/found position
    logic rvalid_reg;                     // read data valid this cycle
    logic [CW-1:0] ridx_reg;              // index of data returning
    logic [RW-1:0] n_reg, k_reg;          // read run length / produced
    sst_pkg::res_t out_reg;
    logic out_valid_reg;

    sst_pkg::entry_t rdata, wdata;
    logic we;
    logic [AW-1:0] raddr, waddr;
    logic [DW-1:0] rrow, wrow;

    sst_mem #(.AW(AW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == sst_pkg::ST_IDLE) && !out_valid_reg;
    assign res.valid = out_valid_reg;
    assign res.data = out_reg;

    wire cmd_fire = cmd.valid && cmd.ready;
    wire [BW-1:0] in_b = BW'(cmd.data.board);
    wire in_ok = {30'd0, cmd.data.board} < NUM_BOARDS;
    wire [CW-1:0] in_size = in_ok ? count_reg[in_b] : '0;

    // comparison of command score against returned entry
    wire [31:0] xs = cmd_reg.score ^ 32'h8000_0000;
    wire [31:0] ys = rdata.score ^ 32'h8000_0000;
    wire beats = lower_reg ? (xs < ys) : (xs > ys);
    wire hit = beats || ((cmd_reg.operation == sst_pkg::OP_ADD) &&
        (rdata.score == cmd_reg.score) && (cmd_reg.time_stamp < rdata.tstamp));

    // read run geometry
    wire [RW-1:0] cnt_cap = ({27'd0, cmd.data.read_count} > MAX_READ) ?
        RW'(MAX_READ) : RW'(cmd.data.read_count);
    wire [CW:0] avail = {1'b0, in_size} - (CW+1)'(cmd.data.start_rank);
    wire start_in = (CW+1)'(cmd.data.start_rank) < {1'b0, in_size};
    wire [RW-1:0] run_n = !start_in ? '0 :
        ((avail > (CW+1)'(cnt_cap)) ? cnt_cap : RW'(avail));

    wire [CW-1:0] rd_rank = cmd_reg.worst_first ?
        (size_reg - CW'(1) - CW'(cmd_reg.start_rank) - CW'(k_reg)) :
        (CW'(cmd_reg.start_rank) + CW'(k_reg));

    always_comb
    begin
        rrow = DW'(idx_reg);
        if (state_reg == sst_pkg::ST_SHIFT)
            rrow = DW'(idx_reg - CW'(1));
        else if (state_reg == sst_pkg::ST_READ)
            rrow = DW'(rd_rank);
        raddr = {bsel_reg, rrow};
        wrow = DW'(ridx_reg);
        we = 1'b0;
        wdata = rdata;
        if (state_reg == sst_pkg::ST_SHIFT && rvalid_reg)
        begin
            we = 1'b1;
            wrow = DW'(ridx_reg + CW'(1));
        end
        else if (state_reg == sst_pkg::ST_SHIFT && idx_reg == pos_reg && !rvalid_reg)
        begin
            we = 1'b1;
            wrow = DW'(pos_reg);
            wdata = '{score: cmd_reg.score, tstamp: cmd_reg.time_stamp,
                      user: cmd_reg.user_id, tag: cmd_reg.extra_tag};
        end
        waddr = {bsel_reg, wrow};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sst_pkg::ST_IDLE:
                if (cmd_fire)
                begin
                    if (cmd.data.operation == sst_pkg::OP_CLEAR)
                        state_next = sst_pkg::ST_OUT;
                    else if (cmd.data.operation == sst_pkg::OP_READ)
                        state_next = (run_n == '0) ? sst_pkg::ST_OUT : sst_pkg::ST_READ;
                    else if (cmd.data.operation == sst_pkg::OP_ADD &&
                             (!in_ok || in_size >= CW'(TABLE_DEPTH)))
                        state_next = sst_pkg::ST_OUT;
                    else
                        state_next = sst_pkg::ST_SCAN;
                end
            sst_pkg::ST_SCAN:
                if ((rvalid_reg && hit) || (!rvalid_reg && idx_reg >= size_reg) ||
                    (rvalid_reg && ridx_reg + CW'(1) >= size_reg))
                    state_next = (cmd_reg.operation == sst_pkg::OP_ADD) ?
                        sst_pkg::ST_SHIFT : sst_pkg::ST_OUT;
            sst_pkg::ST_SHIFT:
                if (!rvalid_reg && idx_reg == pos_reg)
                    state_next = sst_pkg::ST_OUT;
            sst_pkg::ST_READ:
                if (k_reg == n_reg && !out_valid_reg)
                    state_next = sst_pkg::ST_IDLE;
            sst_pkg::ST_OUT:
                state_next = sst_pkg::ST_IDLE;
            default: state_next = sst_pkg::ST_IDLE;
        endcase
    end

    assign idx_next = idx_reg + CW'(1);

    // memory read started this cycle; its data returns next cycle
    wire issue =
        ((state_reg == sst_pkg::ST_SCAN) && (state_next == sst_pkg::ST_SCAN) &&
         (idx_reg < size_reg)) ||
        ((state_reg == sst_pkg::ST_SHIFT) && !rvalid_reg && (idx_reg > pos_reg)) ||
        ((state_reg == sst_pkg::ST_READ) && !rvalid_reg && !out_valid_reg &&
         (k_reg != n_reg));
    wire out_set = (state_reg == sst_pkg::ST_OUT) ||
        ((state_reg == sst_pkg::ST_READ) && rvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sst_pkg::ST_IDLE;
            lower_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_BOARDS; i++)
                count_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
                lower_reg <= cfg.data;
            out_valid_reg <= out_set || (out_valid_reg && !res.ready);
            rvalid_reg <= issue;
            case (state_reg)
                sst_pkg::ST_IDLE:
                    if (cmd_fire)
                    begin
                        cmd_reg <= cmd.data;
                        bsel_reg <= in_ok ? in_b : '0;
                        size_reg <= in_size;
                        idx_reg <= '0;
                        ridx_reg <= '0;
                        pos_reg <= in_size;
                        n_reg <= run_n;
                        k_reg <= '0;
                        out_reg <= '{rank: '0,
                            valid_res: (cmd.data.operation == sst_pkg::OP_CLEAR) ||
                                       (cmd.data.operation == sst_pkg::OP_PROPOSE),
                            board_size: (cmd.data.operation == sst_pkg::OP_CLEAR) ?
                                        7'd0 : 7'(in_size),
                            read_index: '0, entry_user: '0, entry_score: '0,
                            entry_tag: '0, last: 1'b1};
                        if (cmd.data.operation == sst_pkg::OP_CLEAR && in_ok)
                            count_reg[in_b] <= '0;
                    end
                sst_pkg::ST_SCAN:
                begin
                    if (state_next != sst_pkg::ST_SCAN)
                    begin
                        // found position fixed; shift starts at the tail
                        idx_reg <= size_reg;
                        out_reg.valid_res <= 1'b1;
                        if (rvalid_reg && hit)
                        begin
                            pos_reg <= ridx_reg;
                            out_reg.rank <= 7'(ridx_reg);
                        end
                        else
                            out_reg.rank <= 7'(size_reg);
                        if (cmd_reg.operation == sst_pkg::OP_ADD)
                        begin
                            out_reg.board_size <= 7'(size_reg + CW'(1));
                            count_reg[bsel_reg] <= size_reg + CW'(1);
                        end
                    end
                    else if (issue)
                    begin
                        ridx_reg <= idx_reg;
                        idx_reg <= idx_next;
                    end
                end
                sst_pkg::ST_SHIFT:
                begin
                    // read idx-1, write it to idx next cycle; then place new entry
                    if (issue)
                    begin
                        ridx_reg <= idx_reg - CW'(1);
                        idx_reg <= idx_reg - CW'(1);
                    end
                end
                sst_pkg::ST_READ:
                begin
                    if (rvalid_reg)
                    begin
                        out_reg.rank <= 7'(ridx_reg);
                        out_reg.valid_res <= 1'b1;
                        out_reg.read_index <= 4'(k_reg);
                        out_reg.entry_user <= rdata.user;
                        out_reg.entry_score <= rdata.score;
                        out_reg.entry_tag <= rdata.tag;
                        out_reg.last <= (k_reg + RW'(1)) == n_reg;
                        k_reg <= k_reg + RW'(1);
                    end
                    else if (issue)
                        ridx_reg <= rd_rank;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: test/tb_sorted_score_table.sv
// Self-checking sorted score table bench: directed table, board fill, then random traffic.
`timescale 1ns / 1ps
module tb_sorted_score_table;

    localparam int DEPTH = 64;
    localparam int BOARDS = 4;
    localparam int READ_MAX = 16;
    localparam int CYCLE_LIMIT = 900000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sst_cmd_if cmd_ch();
    sst_res_if res_ch();
    sst_cfg_if cfg_ch();

    sorted_score_table u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_ch.sink),
        .res(res_ch.source),
        .cfg(cfg_ch.sink)
    );

    always #5 clk = ~clk;

    // shadow of the board contents
    logic lower_better;
    int unsigned board_len [BOARDS];
    sst_pkg::entry_t shadow_board [BOARDS][DEPTH];

    sst_pkg::res_t pending_results [$];
    int error_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_receiver = 1'b0;

    function automatic bit outranks(logic [31:0] a, logic [31:0] b);
        if (lower_better)
            return $signed(a) < $signed(b);
        return $signed(a) > $signed(b);
    endfunction

    function automatic sst_pkg::res_t single_result(int unsigned rank, bit ok,
                                                    int unsigned size);
        sst_pkg::res_t r;
        r = '0;
        r.rank = rank[6:0];
        r.valid_res = ok;
        r.board_size = size[6:0];
        r.last = 1'b1;
        return r;
    endfunction

    // update the shadow boards and queue the results one command causes
    task automatic predict_command(input sst_pkg::cmd_t c);
        int unsigned b;
        int unsigned size;
        int unsigned pos;
        int unsigned n;
        int unsigned cnt;
        int unsigned r;
        sst_pkg::res_t o;
        b = c.board;
        size = board_len[b];
        case (c.operation)
            sst_pkg::OP_PROPOSE:
            begin
                pos = size;
                for (int i = 0; i < size; i++)
                    if (outranks(c.score, shadow_board[b][i].score))
                    begin
                        pos = i;
                        break;
                    end
                pending_results.push_back(single_result(pos, 1'b1, size));
            end
            sst_pkg::OP_ADD:
            begin
                if (size >= DEPTH)
                    pending_results.push_back(single_result(0, 1'b0, size));
                else
                begin
                    pos = size;
                    for (int i = 0; i < size; i++)
                        if (outranks(c.score, shadow_board[b][i].score) ||
                            (c.score == shadow_board[b][i].score &&
                             c.time_stamp < shadow_board[b][i].tstamp))
                        begin
                            pos = i;
                            break;
                        end
                    for (int i = size; i > pos; i--)
                        shadow_board[b][i] = shadow_board[b][i-1];
                    shadow_board[b][pos] = '{c.score, c.time_stamp, c.user_id, c.extra_tag};
                    board_len[b] = size + 1;
                    pending_results.push_back(single_result(pos, 1'b1, size + 1));
                end
            end
            sst_pkg::OP_CLEAR:
            begin
                board_len[b] = 0;
                pending_results.push_back(single_result(0, 1'b1, 0));
            end
            default:
            begin
                cnt = (c.read_count > READ_MAX) ? READ_MAX : c.read_count;
                n = 0;
                if (c.start_rank < size)
                    n = (size - c.start_rank < cnt) ? size - c.start_rank : cnt;
                if (n == 0)
                    pending_results.push_back(single_result(0, 1'b0, size));
                for (int i = 0; i < n; i++)
                begin
                    r = c.worst_first ? size - 1 - c.start_rank - i : c.start_rank + i;
                    o = single_result(r, 1'b1, size);
                    o.read_index = i[3:0];
                    o.entry_user = shadow_board[b][r].user;
                    o.entry_score = shadow_board[b][r].score;
                    o.entry_tag = shadow_board[b][r].tag;
                    o.last = (i + 1 == n);
                    pending_results.push_back(o);
                end
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_score_table: mismatch");
            $finish;
        end
    end

    // receiver: check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10) $display("unexpected result %p", res_ch.data);
                end
                else
                begin
                    sst_pkg::res_t e;
                    e = pending_results.pop_front();
                    if (res_ch.data !== e)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("result differs: expected %p got %p", e, res_ch.data);
                    end
                end
            end
            res_ch.ready <= !hold_receiver && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up between back-to-back items; idle gaps and drains drop it
    task automatic send_command(input sst_pkg::cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data <= c;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        predict_command(c);
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2 * DEPTH + 20) @(posedge clk);
    endtask

    task automatic write_order(input logic lower);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= lower;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        lower_better = lower;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic sst_pkg::cmd_t make_cmd(logic [1:0] op, logic [1:0] b,
                                               logic [31:0] s, logic [31:0] t,
                                               logic [5:0] st, logic [4:0] cnt, bit worst);
        sst_pkg::cmd_t c;
        c.operation = op;
        c.board = b;
        c.user_id = 16'($urandom);
        c.score = s;
        c.extra_tag = 16'($urandom);
        c.time_stamp = t;
        c.start_rank = st;
        c.read_count = cnt;
        c.worst_first = worst;
        return c;
    endfunction

    // random command, mostly adds and reads on narrow score ranges for ties
    function automatic sst_pkg::cmd_t random_cmd();
        int unsigned pick;
        logic [31:0] s;
        logic [31:0] t;
        logic [5:0] st;
        pick = $urandom_range(99);
        s = ($urandom_range(3) == 0) ? $urandom : $urandom_range(8) - 4;
        t = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
        st = ($urandom_range(20) == 0) ? 6'($urandom) : 6'($urandom_range(12));
        if (pick < 45) return make_cmd(sst_pkg::OP_ADD, 2'($urandom), s, t, 6'd0, 5'd1, 1'b0);
        if (pick < 65)
            return make_cmd(sst_pkg::OP_PROPOSE, 2'($urandom), s, t, 6'd0, 5'd1, 1'b0);
        if (pick < 68)
            return make_cmd(sst_pkg::OP_CLEAR, 2'($urandom), s, t, 6'd0, 5'd1, 1'b0);
        return make_cmd(sst_pkg::OP_READ, 2'($urandom), s, t, st, 5'($urandom),
                        1'($urandom));
    endfunction

    typedef struct {
        sst_pkg::cmd_t c;
        bit checked;
        sst_pkg::res_t want;
    } row_t;

    initial begin
        row_t plan [$];
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = 1'b0;
        lower_better = 1'b0;
        foreach (board_len[i]) board_len[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        plan.push_back('{make_cmd(sst_pkg::OP_READ, 0, 0, 0, 0, 1, 0), 1,
                         single_result(0, 0, 0)});
        plan.push_back('{make_cmd(sst_pkg::OP_PROPOSE, 3, 5, 0, 0, 1, 0), 1,
                         single_result(0, 1, 0)});
        plan.push_back('{make_cmd(sst_pkg::OP_ADD, 0, 32'h7fffffff, 9, 0, 1, 0), 1,
                         single_result(0, 1, 1)});
        plan.push_back('{make_cmd(sst_pkg::OP_ADD, 0, 32'h80000000, 0, 0, 1, 0), 0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_ADD, 0, 32'h7fffffff, 3, 0, 1, 0), 0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_ADD, 0, 32'h7fffffff, 3, 0, 1, 0), 0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_ADD, 0, 32'hffffffff, 32'hffffffff, 0, 1, 0),
                         0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_PROPOSE, 0, 32'h7fffffff, 0, 0, 1, 0), 0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_PROPOSE, 0, 0, 0, 0, 1, 0), 0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_READ, 0, 0, 0, 0, 31, 0), 0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_READ, 0, 0, 0, 1, 2, 1), 0, '0});
        plan.push_back('{make_cmd(sst_pkg::OP_READ, 0, 0, 0, 63, 16, 1), 1,
                         single_result(0, 0, 5)});
        plan.push_back('{make_cmd(sst_pkg::OP_READ, 0, 0, 0, 5, 0, 0), 1,
                         single_result(0, 0, 5)});
        plan.push_back('{make_cmd(sst_pkg::OP_CLEAR, 0, 0, 0, 0, 1, 0), 1,
                         single_result(0, 1, 0)});
        plan.push_back('{make_cmd(sst_pkg::OP_CLEAR, 2, 0, 0, 0, 1, 0), 1,
                         single_result(0, 1, 0)});
        send_idle_pct = 13;
        recv_idle_pct = 65;
        foreach (plan[i])
        begin
            send_command(plan[i].c);
            if (plan[i].checked && pending_results[$] !== plan[i].want)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("row %0d: expected %p, predicted %p", i, plan[i].want,
                             pending_results[$]);
            end
        end

        // fill a board to the top so the full case shows, with the receiver held off at first
        fork
            begin
                hold_receiver = 1'b1;
                repeat (300) @(posedge clk);
                hold_receiver = 1'b0;
            end
            for (int i = 0; i < 66; i++)
                send_command(make_cmd(sst_pkg::OP_ADD, 1, $urandom_range(40),
                                      $urandom_range(3), 0, 1, 0));
        join
        send_command(make_cmd(sst_pkg::OP_READ, 1, 0, 0, 48, 16, 0));
        send_command(make_cmd(sst_pkg::OP_READ, 1, 0, 0, 0, 16, 1));

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 65 : 0;
            recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 13 : 0;
            write_order(phase == 1);
            for (int i = 0; i < 120; i++)
                send_command(random_cmd());
        end

        drain_results();
        if (error_count == 0)
            $display("sorted_score_table: match");
        else
            $display("sorted_score_table: mismatch");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/sst_pkg.sv
hw/rtl/sst_if.sv
hw/rtl/sst_mem.sv
hw/rtl/sorted_score_table.sv
test/tb_sorted_score_table.sv
